### rtl/core/opaque_span_extractor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the opaque span extractor
// Shared property forms used by the core and the result queue.
// ----------------------------------------------------------------------------
`ifndef OPAQUE_SPAN_EXTRACTOR_ASSERT_SVH
`define OPAQUE_SPAN_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define OSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define OSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ose_pkg.sv
// ----------------------------------------------------------------------------
// ose_pkg
// Types and constants shared by the opaque span extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ose_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// column / row counters and the register width that can hold the maximum
	localparam int COL_W = 10;
	localparam int DIM_W = 11;
	localparam int IDX_W = 20;
	localparam int KEY_W = 16;

	// result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	typedef enum logic [1:0] {
		CFG_KEY    = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_SPAN = 1'b0,
		KIND_ROW  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [9:0]        span_start;
		logic [10:0]       span_length;
		logic [9:0]        row_number;
		logic [18:0]       span_index;
		logic [9:0]        row_span_count;
		logic [19:0]       row_first_index;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

### rtl/core/ose_cfg.sv
// ----------------------------------------------------------------------------
// ose_cfg
// Configuration registers; presents the key and the clamped frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module ose_cfg import ose_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [KEY_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [KEY_W-1:0] key_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	assign cfg_ready = 1'b1;

	// take register words; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_KEY:    key_q    <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp size to 1..max
	always_comb begin
		cfg.key = key_q;
		if (width_q == '0)
			cfg.width = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_WIDTH))
			cfg.width = DIM_W'(MAX_WIDTH);
		else
			cfg.width = width_q;
		if (height_q == '0)
			cfg.height = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_HEIGHT))
			cfg.height = DIM_W'(MAX_HEIGHT);
		else
			cfg.height = height_q;
	end

endmodule

`default_nettype wire

### rtl/core/ose_core.sv
// ----------------------------------------------------------------------------
// ose_core
// Pixel input register, run tracking and span / row summary generation.
// ----------------------------------------------------------------------------
`default_nettype none

module ose_core import ose_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  cfg_t                  cfg,
	input  wire logic             pix_valid,
	output logic                  pix_stall,
	input  wire logic [KEY_W-1:0] pixel,
	input  wire logic             room,
	output logic [1:0]            push_n,
	output res_t                  e0,
	output res_t                  e1
);

`include "opaque_span_extractor_assert.svh"

	logic             valid_s1;
	logic [KEY_W-1:0] pixel_s1;

	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] row_q;
	logic             in_run_q;
	logic [COL_W-1:0] run_start_q;
	logic [COL_W-1:0] spans_q;
	logic [IDX_W-1:0] base_q;
	logic [IDX_W-1:0] next_q;

	logic             proc;
	logic             accept;
	logic             opaque;
	logic             row_end;
	logic             frame_end;
	logic             start_run;
	logic             key_close;
	logic             span_close;
	logic [COL_W-1:0] run_st;
	logic [DIM_W-1:0] col_nx;
	logic [DIM_W-1:0] row_nx;
	logic [DIM_W-1:0] span_len;
	logic [COL_W-1:0] spans_inc;
	logic [IDX_W-1:0] next_inc;
	res_t             span_rec;
	res_t             summary;

	assign proc      = valid_s1 && room;
	assign pix_stall = valid_s1 && !room;
	assign accept    = pix_valid && !pix_stall;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (proc)
			valid_s1 <= 1'b0;
	end

	// hold the pixel word
	always_ff @(posedge clk) begin
		if (accept)
			pixel_s1 <= pixel;
	end

	// classify the pixel and decide what closes
	always_comb begin
		opaque     = pixel_s1 != cfg.key;
		col_nx     = DIM_W'(col_q) + DIM_W'(1);
		row_nx     = DIM_W'(row_q) + DIM_W'(1);
		row_end    = col_nx >= cfg.width;
		frame_end  = row_nx >= cfg.height;
		start_run  = opaque && !in_run_q;
		key_close  = !opaque && in_run_q;
		run_st     = start_run ? col_q : run_start_q;
		span_close = key_close || (row_end && opaque);
		if (key_close)
			span_len = DIM_W'(col_q - run_start_q);
		else
			span_len = col_nx - DIM_W'(run_st);
		spans_inc  = spans_q + COL_W'(span_close);
		next_inc   = next_q + IDX_W'(span_close);
	end

	// build the two possible records
	always_comb begin
		span_rec                 = '0;
		span_rec.kind            = KIND_SPAN;
		span_rec.span_start      = run_st;
		span_rec.span_length     = span_len;
		span_rec.row_number      = row_q;
		span_rec.span_index      = next_q[18:0];
		span_rec.last            = !row_end;

		summary                  = '0;
		summary.kind             = KIND_ROW;
		summary.row_number       = row_q;
		summary.row_span_count   = spans_inc;
		summary.row_first_index  = base_q;
		summary.last             = 1'b1;

		e0     = span_close ? span_rec : summary;
		e1     = summary;
		push_n = proc ? (2'(span_close) + 2'(row_end)) : 2'd0;
	end

	// advance column, row and span counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			in_run_q    <= 1'b0;
			run_start_q <= '0;
			spans_q     <= '0;
			base_q      <= '0;
			next_q      <= '0;
		end else if (proc) begin
			run_start_q <= run_st;
			if (row_end) begin
				col_q    <= '0;
				in_run_q <= 1'b0;
				spans_q  <= '0;
				if (frame_end) begin
					row_q  <= '0;
					next_q <= '0;
					base_q <= '0;
				end else begin
					row_q  <= row_nx[COL_W-1:0];
					next_q <= next_inc;
					base_q <= next_inc;
				end
			end else begin
				col_q    <= col_nx[COL_W-1:0];
				in_run_q <= opaque;
				spans_q  <= spans_inc;
				next_q   <= next_inc;
			end
		end
	end

	`OSE_ASSERT_NXT(a_row_wrap, clk, arst_n, proc && row_end, (col_q == '0) && !in_run_q, "column or run not cleared at row end")
	`OSE_ASSERT_IMP(a_run_order, clk, arst_n, in_run_q, run_start_q <= col_q, "run start beyond current column")

endmodule

`default_nettype wire

### rtl/core/ose_fifo.sv
// ----------------------------------------------------------------------------
// ose_fifo
// Result queue: takes up to two records a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module ose_fifo import ose_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_n,
	input  res_t            e0,
	input  res_t            e1,
	output logic            room,
	output logic            res_valid,
	input  wire logic       res_stall,
	output res_t            head
);

`include "opaque_span_extractor_assert.svh"

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic [FIFO_AW-1:0] wr_nx;
	logic               pop;

	assign wr_nx     = wr_q + FIFO_AW'(1);
	assign res_valid = cnt_q != '0;
	assign pop       = res_valid && !res_stall;
	assign head      = mem_q[rd_q];
	assign room      = cnt_q <= FIFO_CW'(FIFO_DEPTH - 2);

	// store incoming records
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_q] <= e0;
		if (push_n == 2'd2)
			mem_q[wr_nx] <= e1;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_AW'(push_n);
			if (pop)
				rd_q <= rd_q + FIFO_AW'(1);
			cnt_q <= cnt_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

	`OSE_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= FIFO_CW'(FIFO_DEPTH), "result queue count out of range")
	`OSE_ASSERT_IMP(a_no_overflow, clk, arst_n, push_n != 2'd0, (cnt_q + FIFO_CW'(push_n)) <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")

endmodule

`default_nettype wire

### rtl/core/opaque_span_extractor.sv
// A pixel word is registered in the input stage, and its records are written into the result
// queue once the queue has room; the first record is then presented at the queue head.
// Throughput: one pixel per cycle while results drain; a row end that closes a span gives
// two records, and the single-record output port then sets the rate (input stalls at > 2).
// Reset: arst_n clears counters, run state and the queue; registers take key 0, size 1024x1024.
// ----------------------------------------------------------------------------
// opaque_span_extractor
// Color-key span encoder: emits opaque span records and per-row summaries.
// ----------------------------------------------------------------------------
`default_nettype none

module opaque_span_extractor import ose_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [KEY_W-1:0] cfg_data,
	input  wire logic             pix_valid,
	output logic                  pix_stall,
	input  wire logic [15:0]      pixel,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic                  kind,
	output logic [9:0]            span_start,
	output logic [10:0]           span_length,
	output logic [9:0]            row_number,
	output logic [18:0]           span_index,
	output logic [9:0]            row_span_count,
	output logic [19:0]           row_first_index,
	output logic                  last
);

	cfg_t       cfg;
	logic       room;
	logic [1:0] push_n;
	res_t       e0;
	res_t       e1;
	res_t       head;

	ose_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ose_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel     (pixel),
		.room      (room),
		.push_n    (push_n),
		.e0        (e0),
		.e1        (e1)
	);

	ose_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.e0        (e0),
		.e1        (e1),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.head      (head)
	);

	// unpack the head record
	assign kind            = head.kind;
	assign span_start      = head.span_start;
	assign span_length     = head.span_length;
	assign row_number      = head.row_number;
	assign span_index      = head.span_index;
	assign row_span_count  = head.row_span_count;
	assign row_first_index = head.row_first_index;
	assign last            = head.last;

endmodule

`default_nettype wire

### sim/ose_span_checker.sv
// ----------------------------------------------------------------------------
// ose_span_checker
// Watches the register, pixel and record channels of the opaque span
// extractor, encodes every accepted pixel word into the span records and row
// summaries it must cause, and compares each accepted record, field by field,
// against the oldest one still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module ose_span_checker import ose_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [KEY_W-1:0] cfg_data,
	input  wire logic             pix_valid,
	input  wire logic             pix_stall,
	input  wire logic [15:0]      pixel,
	input  wire logic             res_valid,
	input  wire logic             res_stall,
	input  wire logic             kind,
	input  wire logic [9:0]       span_start,
	input  wire logic [10:0]      span_length,
	input  wire logic [9:0]       row_number,
	input  wire logic [18:0]      span_index,
	input  wire logic [9:0]       row_span_count,
	input  wire logic [19:0]      row_first_index,
	input  wire logic             last,
	output int                    mismatches,
	output int                    records_pending,
	output int                    records_seen,
	output int                    spans_seen
);

	localparam int REPORT_LIMIT = 10;

	// register copy
	logic [KEY_W-1:0] key_color;
	logic [DIM_W-1:0] row_width;
	logic [DIM_W-1:0] image_height;

	// encoder state
	logic [COL_W-1:0] column;
	logic [COL_W-1:0] row_count;
	logic [COL_W-1:0] run_start;
	logic [COL_W-1:0] row_spans;
	logic             in_run;
	logic [IDX_W-1:0] row_base;
	logic [IDX_W-1:0] next_index;

	// records owed by the block, oldest first
	res_t records_due[$];
	int   err_cnt  = 0;
	int   rec_cnt  = 0;
	int   span_cnt = 0;

	// clamp a size register into 1..hi
	function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
		if (v == '0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	// close the open run as a span record of the given length
	function automatic res_t close_run(int len);
		res_t r;
		r = '0;
		r.kind        = KIND_SPAN;
		r.span_start  = run_start;
		r.span_length = len[10:0];
		r.row_number  = row_count;
		r.span_index  = next_index[18:0];
		next_index    = next_index + 1'b1;
		row_spans     = row_spans + 1'b1;
		in_run        = 1'b0;
		return r;
	endfunction

	// advance the encoder by one pixel word and queue the records it causes
	task automatic encode_pixel(input logic [15:0] px);
		res_t recs[2];
		int   n;
		int   w;
		int   h;
		logic opaque;
		logic row_end;
		w       = clamp_dim(row_width, MAX_WIDTH);
		h       = clamp_dim(image_height, MAX_HEIGHT);
		opaque  = (px != key_color);
		row_end = (int'(column) + 1) >= w;
		n       = 0;

		// open a run on an opaque pixel, close it on a key pixel
		if (opaque && !in_run) begin
			in_run    = 1'b1;
			run_start = column;
		end else if (!opaque && in_run) begin
			recs[n] = close_run(int'(column) - int'(run_start));
			n++;
		end

		// close the row: flush the run, then summarize
		if (row_end) begin
			if (in_run) begin
				recs[n] = close_run(int'(column) + 1 - int'(run_start));
				n++;
			end
			recs[n]                 = '0;
			recs[n].kind            = KIND_ROW;
			recs[n].row_number      = row_count;
			recs[n].row_span_count  = row_spans;
			recs[n].row_first_index = row_base;
			n++;
			column    = '0;
			in_run    = 1'b0;
			row_spans = '0;
			// restart row and span numbering at frame end
			if (int'(row_count) + 1 >= h) begin
				row_count  = '0;
				next_index = '0;
			end else begin
				row_count = row_count + 1'b1;
			end
			row_base = next_index;
		end else begin
			column = column + 1'b1;
		end

		if (n > 0)
			recs[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			records_due.push_back(recs[i]);
	endtask

	// compare one accepted record with the oldest owed one
	task automatic check_record();
		res_t want;
		res_t got;
		got.kind            = kind_t'(kind);
		got.span_start      = span_start;
		got.span_length     = span_length;
		got.row_number      = row_number;
		got.span_index      = span_index;
		got.row_span_count  = row_span_count;
		got.row_first_index = row_first_index;
		got.last            = last;
		rec_cnt++;
		if (kind == KIND_SPAN)
			span_cnt++;

		if (records_due.size() == 0) begin
			err_cnt++;
			if (err_cnt <= REPORT_LIMIT)
				$display("unexpected record %0d: kind %0d start %0d length %0d",
					rec_cnt, got.kind, got.span_start, got.span_length);
		end else begin
			want = records_due.pop_front();
			if (got !== want) begin
				err_cnt++;
				if (err_cnt <= REPORT_LIMIT) begin
					$display("mismatch at record %0d", rec_cnt);
					$display("  expected kind %0d start %0d length %0d row %0d index %0d",
						want.kind, want.span_start, want.span_length,
						want.row_number, want.span_index);
					$display("           count %0d first %0d last %0d",
						want.row_span_count, want.row_first_index, want.last);
					$display("  actual   kind %0d start %0d length %0d row %0d index %0d",
						got.kind, got.span_start, got.span_length,
						got.row_number, got.span_index);
					$display("           count %0d first %0d last %0d",
						got.row_span_count, got.row_first_index, got.last);
				end
			end
		end
	endtask

	// sample all three channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_color    = '0;
			row_width    = DIM_W'(MAX_WIDTH);
			image_height = DIM_W'(MAX_HEIGHT);
			column       = '0;
			row_count    = '0;
			run_start    = '0;
			row_spans    = '0;
			in_run       = 1'b0;
			row_base     = '0;
			next_index   = '0;
			records_due.delete();
		end else begin
			// track register writes; drop unknown indexes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KEY:    key_color    = cfg_data;
					CFG_WIDTH:  row_width    = cfg_data[DIM_W-1:0];
					CFG_HEIGHT: image_height = cfg_data[DIM_W-1:0];
					default:    ;
				endcase
			end
			if (pix_valid && !pix_stall)
				encode_pixel(pixel);
			if (res_valid && !res_stall)
				check_record();
		end
		mismatches      <= err_cnt;
		records_pending <= records_due.size();
		records_seen    <= rec_cnt;
		spans_seen      <= span_cnt;
	end

endmodule

`default_nettype wire

### sim/opaque_span_extractor_tb.sv
// ----------------------------------------------------------------------------
// opaque_span_extractor_tb
// Drives register writes and pixel words into the span extractor under
// several idling mixes and a long receiver hold-off; the checker beside the
// block predicts and compares every record, and this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module opaque_span_extractor_tb;

	import ose_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;

	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 250;
	localparam int RANDOM_ITEMS = 1000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idling_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [KEY_W-1:0] cfg_data;
	logic             pix_valid;
	logic             pix_stall;
	logic [15:0]      pixel;
	logic             res_valid;
	logic             res_stall;
	logic             kind;
	logic [9:0]       span_start;
	logic [10:0]      span_length;
	logic [9:0]       row_number;
	logic [18:0]      span_index;
	logic [9:0]       row_span_count;
	logic [19:0]      row_first_index;
	logic             last;

	int mismatches;
	int records_pending;
	int records_seen;
	int spans_seen;

	int idle_pct    = 0;
	int stall_pct   = 0;
	int hold_req    = 0;
	int hold_left   = 0;
	int quiet       = 0;
	int pixels_sent = 0;

	always #5 clk = ~clk;

	opaque_span_extractor dut (.*);

	ose_span_checker span_chk (.*);

	// receiver: random stall, or a counted hold-off on request
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_req  = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(99, 0) < stall_pct);
			end
		end
	end

	// watchdog: end the run after too long without any handshake
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d records owed", quiet,
				records_pending);
			$display("tb: failure");
			$finish;
		end
	end

	task automatic set_idling(idling_t mode);
		case (mode)
			IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin idle_pct = 69; stall_pct = 0;  end
			IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 69; end
			default:       begin idle_pct = 28; stall_pct = 28; end
		endcase
	endtask

	// offer one register word and hold it until taken; valid stays up
	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	// drop pixel valid and wait until every owed record is back
	task automatic settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (records_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// reprogram all size and key registers once the block is idle
	task automatic program_regs(logic [15:0] key, logic [15:0] wdata, logic [15:0] hdata,
		bit poke_unused);
		settle();
		if (poke_unused)
			write_reg(CFG_UNUSED, 16'($urandom()));
		write_reg(CFG_KEY, key);
		write_reg(CFG_WIDTH, wdata);
		write_reg(CFG_HEIGHT, hdata);
		cfg_valid <= 1'b0;
	endtask

	// offer one pixel word after random idle cycles; hold it while stalled
	task automatic send_pixel(logic [15:0] px);
		while ($urandom_range(99, 0) < idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel     <= px;
		do @(posedge clk); while (pix_stall !== 1'b0);
		pixels_sent++;
	endtask

	// stream alternating key and opaque runs with some noise
	task automatic run_phase(int count, logic [15:0] key);
		bit          in_key;
		logic [15:0] px;
		in_key = $urandom_range(1, 0);
		repeat (count) begin
			if ($urandom_range(99, 0) < 30)
				in_key = !in_key;
			if ($urandom_range(99, 0) < 10)
				px = 16'($urandom());
			else if (in_key)
				px = key;
			else
				px = 16'($urandom());
			send_pixel(px);
		end
	endtask

	initial begin
		logic [15:0] key;
		logic [15:0] wdata;
		logic [15:0] hdata;
		int          n;
		int          phase;
		int          random_sent;
		int          directed_sent;

		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_KEY;
		cfg_data  <= '0;
		pix_valid <= 1'b0;
		pixel     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: width 5 (upper data bits masked off), two rows per frame
		set_idling(IDLE_NONE);
		key = 16'hF81F;
		program_regs(key, 16'hF805, 16'h0002, 1'b1);
		// row 0: span closed by a key pixel, then a run closed at row end
		send_pixel(key);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(key);
		send_pixel(16'h1234);
		// row 1: one full-row span, then frame wrap
		repeat (5) send_pixel(16'hFFFF);
		// row 0 again: no spans at all
		repeat (5) send_pixel(key);
		// shrink width and height mid-row and mid-frame
		repeat (3) send_pixel(16'hFFFF);
		program_regs(key, 16'h0002, 16'h0001, 1'b0);
		send_pixel(key);
		// key 0, width 1, height 0 clamped to 1: every pixel ends a row
		key = 16'h0000;
		program_regs(key, 16'h0001, 16'hF800, 1'b0);
		send_pixel(16'h0000);
		send_pixel(16'h0001);
		send_pixel(16'hFFFF);
		directed_sent = pixels_sent;

		// random phases over small frames and every idling mix
		phase       = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(3, 0))
				0:       key = 16'h0000;
				1:       key = 16'hFFFF;
				default: key = 16'($urandom());
			endcase
			case ($urandom_range(7, 0))
				0:       wdata = {5'($urandom()), 11'd0};
				1:       wdata = {5'($urandom()), 11'd1};
				default: wdata = {5'($urandom()), 11'($urandom_range(12, 2))};
			endcase
			if ($urandom_range(7, 0) == 0)
				hdata = {5'($urandom()), 11'd0};
			else
				hdata = {5'($urandom()), 11'($urandom_range(4, 1))};
			program_regs(key, wdata, hdata, $urandom_range(3, 0) == 0);
			set_idling(idling_t'(phase % 4));
			// hold the receiver off while the sender keeps offering
			if (phase == 2)
				hold_req = 1;
			n = $urandom_range(160, 60);
			run_phase(n, key);
			random_sent += n;
			phase++;
		end

		// oversized size registers clamp to the maximum; shrink mid-row to close it
		key = 16'hFFFF;
		program_regs(key, 16'hFFFF, 16'hFFFF, 1'b0);
		set_idling(IDLE_BOTH);
		repeat (60) send_pixel(16'($urandom_range(16'hFFFE, 0)));
		program_regs(key, 16'h0002, 16'h0001, 1'b0);
		send_pixel(16'h0001);

		settle();
		$display("summary: %0d pixel words (%0d directed, %0d random in %0d phases), %0d records",
			pixels_sent, directed_sent, random_sent, phase, records_seen);
		$display("summary: %0d spans, %0d row summaries, size registers zero to oversized",
			spans_seen, records_seen - spans_seen);
		if (mismatches == 0 && records_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

### opaque_span_extractor.f
+incdir+rtl/core
rtl/core/ose_pkg.sv
rtl/core/ose_cfg.sv
rtl/core/ose_core.sv
rtl/core/ose_fifo.sv
rtl/core/opaque_span_extractor.sv
sim/ose_span_checker.sv
sim/opaque_span_extractor_tb.sv
